FILE: rtl/assert_macros.svh
// assertion macros used by the checker file afwc_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define ASSERT_RST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// concurrent assertion on clk_i and rst_ni
`define ASSERT_CLK(lbl, prop) `ASSERT_RST(lbl, clk_i, rst_ni, prop)

`endif

FILE: rtl/afwc_pkg.sv
// types, constants and functions of the frame whitening and crc block
// no dependencies
`timescale 1ns / 1ps

package afwc_pkg;

  localparam int unsigned MaxFrame   = 64;
  localparam int unsigned TableDepth = 128;
  localparam int unsigned TabIdxW    = $clog2(TableDepth);
  localparam int unsigned PaddrW     = 5;

  localparam logic [15:0] CrcPoly    = 16'h1021;
  localparam logic [4:0]  WhitenBias = 5'd9;

  typedef enum logic [2:0] {
    REG_WHITEN_START = 3'd0,
    REG_WHITEN_LEN   = 3'd1,
    REG_CRC_START    = 3'd2,
    REG_CRC_LEN      = 3'd3,
    REG_FRAME_LEN    = 3'd4,
    REG_SALT         = 3'd5
  } afwc_reg_e;

  typedef struct packed {
    logic [5:0] whiten_start;
    logic [6:0] whiten_len;
    logic [5:0] crc_start;
    logic [6:0] crc_len;
    logic [6:0] frame_len;
    logic [1:0] salt;
  } afwc_cfg_t;

  localparam afwc_cfg_t CfgReset = '{
    whiten_start: 6'd9,
    whiten_len:   7'd18,
    crc_start:    6'd7,
    crc_len:      7'd22,
    frame_len:    7'd29,
    salt:         2'd0
  };

  // one classified byte on its way to the crc sequencer
  typedef struct packed {
    logic [7:0]  data;
    logic        crc_en;
    logic        first;
    logic [15:0] seed;
    logic        last;
  } afwc_item_t;

  localparam logic [7:0] WhitenTab [TableDepth] = '{
    8'hB7, 8'hFD, 8'h93, 8'h26, 8'h36, 8'h3F, 8'hF7, 8'hCC,
    8'h34, 8'hA5, 8'hE5, 8'hF1, 8'h71, 8'hD8, 8'h31, 8'h15,
    8'h04, 8'hC7, 8'h23, 8'hC3, 8'h18, 8'h96, 8'h05, 8'h9A,
    8'h07, 8'h12, 8'h80, 8'hE2, 8'hEB, 8'h27, 8'hB2, 8'h75,
    8'hD0, 8'hEF, 8'hAA, 8'hFB, 8'h43, 8'h4D, 8'h33, 8'h85,
    8'h45, 8'hF9, 8'h02, 8'h7F, 8'h50, 8'h3C, 8'h9F, 8'hA8,
    8'h51, 8'hA3, 8'h40, 8'h8F, 8'h92, 8'h9D, 8'h38, 8'hF5,
    8'hBC, 8'hB6, 8'hDA, 8'h21, 8'h10, 8'hFF, 8'hF3, 8'hD2,
    8'hE0, 8'h32, 8'h3A, 8'h0A, 8'h49, 8'h06, 8'h24, 8'h5C,
    8'hC2, 8'hD3, 8'hAC, 8'h62, 8'h91, 8'h95, 8'hE4, 8'h79,
    8'hE7, 8'hC8, 8'h37, 8'h6D, 8'h8D, 8'hD5, 8'h4E, 8'hA9,
    8'h6C, 8'h56, 8'hF4, 8'hEA, 8'h65, 8'h7A, 8'hAE, 8'h08,
    8'hE1, 8'hF8, 8'h98, 8'h11, 8'h69, 8'hD9, 8'h8E, 8'h94,
    8'h9B, 8'h1E, 8'h87, 8'hE9, 8'hCE, 8'h55, 8'h28, 8'hDF,
    8'h8C, 8'hA1, 8'h89, 8'h0D, 8'hBF, 8'hE6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2D, 8'h0F, 8'hB0, 8'h54, 8'hBB, 8'h16
  };

  // crc-16 0x1021, msb first, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/afwc_if.sv
// valid/ready channel interfaces for frame bytes in and output bytes out
// no dependencies
`timescale 1ns / 1ps

interface afwc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [15:0] seed;

  modport source (output valid, output data_byte, output seed, input ready);
  modport sink   (input valid, input data_byte, input seed, output ready);
endinterface

interface afwc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_crc;
  logic       frame_end;

  modport source (output valid, output out_byte, output is_crc, output frame_end, input ready);
  modport sink   (input valid, input out_byte, input is_crc, input frame_end, output ready);
endinterface

FILE: rtl/afwc_fifo.sv
// short queue of classified bytes between front and crc sequencer
// depends on afwc_pkg
`timescale 1ns / 1ps

module afwc_fifo import afwc_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  input  afwc_item_t push_item_i,
  output logic       push_ready_o,
  output logic       pop_valid_o,
  output afwc_item_t pop_item_o,
  input  logic       pop_i
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  afwc_item_t      mem_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            push;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

FILE: rtl/afwc_front.sv
// front end: takes frame bytes, tracks position, whitens and classifies
// depends on afwc_pkg and afwc_if
`timescale 1ns / 1ps

module afwc_front import afwc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  afwc_cfg_t  cfg_i,
  afwc_in_if.sink    in_i,
  output logic       push_valid_o,
  output afwc_item_t push_item_o,
  input  logic       push_ready_i
);

  logic [6:0]         pos_q, pos_d;
  logic [7:0]         seed_low_q, seed_low_d;
  logic               first;
  logic [7:0]         seed_low;
  logic [6:0]         ws_ext, cs_ext;
  logic [6:0]         w_off, c_off;
  logic               in_white, in_crc;
  logic [4:0]         tab_low;
  logic [TabIdxW-1:0] tab_idx;
  logic [7:0]         len_eff;
  logic               last;
  logic               accept;

  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;
  assign accept       = in_i.valid && push_ready_i;

  always_comb begin
    first    = (pos_q == '0);
    seed_low = first ? in_i.seed[7:0] : seed_low_q;

    ws_ext   = {1'b0, cfg_i.whiten_start};
    w_off    = pos_q - ws_ext;
    in_white = (pos_q >= ws_ext) && (w_off < cfg_i.whiten_len);
    tab_low  = seed_low[4:0] + w_off[4:0] + WhitenBias;
    tab_idx  = {cfg_i.salt, tab_low};

    cs_ext   = {1'b0, cfg_i.crc_start};
    c_off    = pos_q - cs_ext;
    in_crc   = (pos_q >= cs_ext) && (c_off < cfg_i.crc_len);

    if (cfg_i.frame_len == '0) begin
      len_eff = 8'd1;
    end else if ({1'b0, cfg_i.frame_len} > 8'(MaxFrame)) begin
      len_eff = 8'(MaxFrame);
    end else begin
      len_eff = {1'b0, cfg_i.frame_len};
    end
    last = (({1'b0, pos_q} + 8'd1) >= len_eff);

    push_item_o.data   = in_white ? (in_i.data_byte ^ WhitenTab[tab_idx] ^ seed_low)
                                  : in_i.data_byte;
    push_item_o.crc_en = in_crc;
    push_item_o.first  = first;
    push_item_o.seed   = in_i.seed;
    push_item_o.last   = last;

    pos_d      = pos_q;
    seed_low_d = seed_low_q;
    if (accept) begin
      pos_d      = last ? '0 : pos_q + 1'b1;
      seed_low_d = seed_low;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      seed_low_q <= '0;
    end else begin
      pos_q      <= pos_d;
      seed_low_q <= seed_low_d;
    end
  end

endmodule

FILE: rtl/afwc_back.sv
// back end: crc sequencer with output register, appends crc after the last byte
// depends on afwc_pkg and afwc_if
`timescale 1ns / 1ps

module afwc_back import afwc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  input  afwc_item_t pop_item_i,
  output logic       pop_o,
  afwc_out_if.source out_o
);

  localparam logic [1:0] SeqData  = 2'd0;
  localparam logic [1:0] SeqCrcLo = 2'd1;
  localparam logic [1:0] SeqCrcHi = 2'd2;

  logic [1:0]  seq_q, seq_d;
  logic [15:0] crc_q, crc_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_crc_q, out_crc_d;
  logic        out_end_q, out_end_d;
  logic        out_free;
  logic [15:0] crc_base, crc_next;

  assign out_free = !out_valid_q || out_o.ready;

  assign out_o.valid     = out_valid_q;
  assign out_o.out_byte  = out_byte_q;
  assign out_o.is_crc    = out_crc_q;
  assign out_o.frame_end = out_end_q;

  always_comb begin
    crc_base = pop_item_i.first ? ~pop_item_i.seed : crc_q;
    crc_next = pop_item_i.crc_en ? crc16_byte(crc_base, pop_item_i.data) : crc_base;

    seq_d       = seq_q;
    crc_d       = crc_q;
    pop_o       = 1'b0;
    out_valid_d = out_free ? 1'b0 : out_valid_q;
    out_byte_d  = out_byte_q;
    out_crc_d   = out_crc_q;
    out_end_d   = out_end_q;

    unique case (seq_q)
      SeqData: begin
        if (out_free && pop_valid_i) begin
          pop_o       = 1'b1;
          out_valid_d = 1'b1;
          out_byte_d  = pop_item_i.data;
          out_crc_d   = 1'b0;
          out_end_d   = 1'b0;
          crc_d       = crc_next;
          if (pop_item_i.last) begin
            seq_d = SeqCrcLo;
          end
        end
      end
      SeqCrcLo: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = crc_q[7:0];
          out_crc_d   = 1'b1;
          out_end_d   = 1'b0;
          seq_d       = SeqCrcHi;
        end
      end
      SeqCrcHi: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = crc_q[15:8];
          out_crc_d   = 1'b1;
          out_end_d   = 1'b1;
          seq_d       = SeqData;
        end
      end
      default: seq_d = SeqData;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SeqData;
      crc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seq_q       <= seq_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_crc_q  <= out_crc_d;
    out_end_q  <= out_end_d;
  end

endmodule

FILE: rtl/adv_frame_whiten_crc.sv
// Advertising frame whitening and CRC-16. Frame bytes enter on in_i, the seed is taken with
// the first byte of each frame; out_o carries each byte, whitened where it falls in the
// whitening window, and after the frame's last byte the two CRC bytes, low byte first.
// Frame bytes pass at one per clock while out_o is not stalled and no CRC byte is going out;
// a frame of N bytes leaves as N+2 transfers. The two CRC transfers each take the single
// output register in the CRC sequencer, and no frame byte is popped while they leave, so
// with the default queue depth in_i is held. A byte accepted on in_i goes into the queue,
// then into the output register, which offers it on out_o; a stalled output backs up through
// the queue to in_i. Registers (APB, byte address 4*i): whiten_start, whiten_len, crc_start,
// crc_len, frame_len, salt; write them only while no frame is in flight.
// Top level; depends on afwc_pkg, afwc_if, afwc_fifo, afwc_front and afwc_back
`timescale 1ns / 1ps

module adv_frame_whiten_crc import afwc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  afwc_in_if.sink           in_i,
  afwc_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  afwc_cfg_t  cfg_q, cfg_d;
  afwc_reg_e  reg_sel;
  logic       cfg_we;
  logic       push_valid, push_ready;
  afwc_item_t push_item;
  logic       pop_valid, pop;
  afwc_item_t pop_item;

  assign pready  = 1'b1;
  assign reg_sel = afwc_reg_e'(paddr[PaddrW-1:2]);
  assign cfg_we  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      unique case (reg_sel)
        REG_WHITEN_START: cfg_d.whiten_start = pwdata[5:0];
        REG_WHITEN_LEN:   cfg_d.whiten_len   = pwdata[6:0];
        REG_CRC_START:    cfg_d.crc_start    = pwdata[5:0];
        REG_CRC_LEN:      cfg_d.crc_len      = pwdata[6:0];
        REG_FRAME_LEN:    cfg_d.frame_len    = pwdata[6:0];
        REG_SALT:         cfg_d.salt         = pwdata[1:0];
        default:          cfg_d              = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_WHITEN_START: prdata = {26'd0, cfg_q.whiten_start};
      REG_WHITEN_LEN:   prdata = {25'd0, cfg_q.whiten_len};
      REG_CRC_START:    prdata = {26'd0, cfg_q.crc_start};
      REG_CRC_LEN:      prdata = {25'd0, cfg_q.crc_len};
      REG_FRAME_LEN:    prdata = {25'd0, cfg_q.frame_len};
      REG_SALT:         prdata = {30'd0, cfg_q.salt};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  afwc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  afwc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_i        (pop)
  );

  afwc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_item_i  (pop_item),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

FILE: rtl/afwc_checker.sv
// port-level checks of output ordering for adv_frame_whiten_crc, bound to the top level
// depends on assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module afwc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       is_crc_i,
  input logic       frame_end_i
);

  logic out_xfer;

  assign out_xfer = out_valid_i && out_ready_i;

  // stalled output holds
  `ASSERT_CLK(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(is_crc_i) && $stable(frame_end_i))

  // frame end only on a crc byte
  `ASSERT_CLK(a_end_is_crc, out_valid_i && frame_end_i |-> is_crc_i)

  // crc high byte directly follows the low byte
  `ASSERT_CLK(a_crc_hi_next, out_xfer && is_crc_i && !frame_end_i |=> out_valid_i && is_crc_i && frame_end_i)

  // after frame end no crc byte until new data
  `ASSERT_CLK(a_no_crc_after_end, out_xfer && frame_end_i |=> !(out_valid_i && is_crc_i))

endmodule

bind adv_frame_whiten_crc afwc_checker u_afwc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .is_crc_i    (out_o.is_crc),
  .frame_end_i (out_o.frame_end)
);
